@@ design/modexp_pkg.sv @@
// ----------------------------------------------------------------------------
// modexp_pkg: shared types and constants for the modular exponentiation block
// Command and status structures between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package modexp_pkg;

  localparam int unsigned DefaultOperandWidth = 32;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,      // capture operands, start base reduction
    OP_MUL_RES,   // start result = result * base mod m
    OP_MUL_SQR,   // start base = base * base mod m
    OP_SHIFT      // drop the low exponent bit
  } modexp_op_t;

  typedef struct packed {
    modexp_op_t op;
  } modexp_cmd_t;

  typedef struct packed {
    logic mm_done;    // multiply-reduce (or base reduce) finished this cycle
    logic exp_zero;   // remaining exponent is zero
    logic exp_lsb;    // low bit of remaining exponent
    logic mod_zero;   // modulus is zero
  } modexp_stat_t;

endpackage

`default_nettype wire

@@ design/modexp_datapath.sv @@
// ----------------------------------------------------------------------------
// modexp_datapath: operand registers and bit-serial multiply-reduce unit
// Interleaved shift-add modular multiplication, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_datapath #(
  parameter int unsigned OPERAND_WIDTH = modexp_pkg::DefaultOperandWidth
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire modexp_pkg::modexp_cmd_t  cmd,
  output modexp_pkg::modexp_stat_t      stat,
  input  wire logic [31:0]              base_value,
  input  wire logic [31:0]              exponent,
  input  wire logic [31:0]              modulus,
  output logic [31:0]                   power_result
);
  import modexp_pkg::*;

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  modv;
  logic [W-1:0]  expv;
  logic [W-1:0]  res;
  logic [W-1:0]  sqb;
  // shared unit: acc, multiplicand and multiplier, the multiplier scanned from MSB
  logic [W-1:0]  acc;
  logic [W-1:0]  mcand;
  logic [W-1:0]  mplier;
  logic [CW-1:0] cnt;
  logic          run;
  logic          to_res;
  logic          done;

  logic [W:0]   dbl;
  logic [W:0]   dbl_red;
  logic [W-1:0] dbl_m;
  logic [W:0]   add;
  logic [W-1:0] acc_next;

  // one step: acc = 2*acc mod m, then + mcand mod m when bit is set
  // (base reduction uses mcand = 1, or 0 when m is 1, so the bits of mplier shift in directly)
  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, modv}) ? dbl - {1'b0, modv} : dbl;
    dbl_m   = dbl_red[W-1:0];
    add     = {1'b0, dbl_m} + (mplier[W-1] ? {1'b0, mcand} : '0);
    acc_next = (add >= {1'b0, modv}) ? W'(add - {1'b0, modv}) : add[W-1:0];
  end

  // registers and unit sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (run) begin
        acc    <= acc_next;
        mplier <= {mplier[W-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
          if (to_res) res <= acc_next;
          else        sqb <= acc_next;
        end
      end else begin
        case (cmd.op)
          OP_LOAD: begin
            modv   <= modulus[W-1:0];
            expv   <= exponent[W-1:0];
            res    <= W'(1);
            // b mod m: shift b in bit by bit, multiplicand 1 (0 when m is 1)
            acc    <= '0;
            mcand  <= (modulus[W-1:0] == W'(1)) ? '0 : W'(1);
            mplier <= base_value[W-1:0];
            to_res <= 1'b0;
            cnt    <= CW'(W);
            run    <= (modulus[W-1:0] != '0);
          end
          OP_MUL_RES: begin
            acc    <= '0;
            mcand  <= sqb;
            mplier <= res;
            to_res <= 1'b1;
            cnt    <= CW'(W);
            run    <= 1'b1;
          end
          OP_MUL_SQR: begin
            acc    <= '0;
            mcand  <= sqb;
            mplier <= sqb;
            to_res <= 1'b0;
            cnt    <= CW'(W);
            run    <= 1'b1;
          end
          OP_SHIFT: expv <= expv >> 1;
          default: ;
        endcase
      end
    end
  end

  assign stat.mm_done  = done;
  assign stat.exp_zero = (expv == '0);
  assign stat.exp_lsb  = expv[0];
  assign stat.mod_zero = (modv == '0);

  assign power_result = stat.mod_zero ? 32'd0 : 32'(res);

endmodule

`default_nettype wire

@@ design/modexp_ctrl.sv @@
// ----------------------------------------------------------------------------
// modexp_ctrl: sequencer for square-and-multiply
// Handshake, exponent scan and output register control.
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output modexp_pkg::modexp_cmd_t       cmd,
  input  wire modexp_pkg::modexp_stat_t stat
);
  import modexp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_SCAN, S_WRES, S_WSQR, S_SHIFT, S_OUT
  } state_t;

  state_t     state;
  modexp_op_t issued_op;

  assign in_stall = (state != S_IDLE);

  // operands are captured at the accepting edge itself
  assign cmd.op = (state == S_IDLE && in_valid) ? OP_LOAD : issued_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      issued_op <= OP_NONE;
    end else begin
      issued_op <= OP_NONE;
      case (state)
        S_IDLE: if (in_valid) begin
          state <= S_LOAD;
        end
        // wait for base reduction (or skip when modulus is zero)
        S_LOAD: begin
          if (stat.mod_zero || stat.mm_done) state <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.mod_zero || stat.exp_zero) begin
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else if (stat.exp_lsb) begin
            issued_op <= OP_MUL_RES;
            state     <= S_WRES;
          end else begin
            issued_op <= OP_MUL_SQR;
            state     <= S_WSQR;
          end
        end
        S_WRES: if (stat.mm_done) begin
          issued_op <= OP_MUL_SQR;
          state     <= S_WSQR;
        end
        S_WSQR: if (stat.mm_done) begin
          issued_op <= OP_SHIFT;
          state     <= S_SHIFT;
        end
        // exponent shifts at the end of this cycle
        S_SHIFT: state <= S_SCAN;
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation: base ^ exponent mod modulus
// Right-to-left square-and-multiply over a shared bit-serial multiply-reduce.
// ----------------------------------------------------------------------------
//  channel  signals                                  direction
//  in       in_valid, in_stall, base_value/exponent/modulus   sink
//  out      out_valid, out_stall, power_result                 source
//
// Each item runs a base reduction, then for each exponent bit scanned a squaring,
// preceded by a multiply into the result when that bit is set, then a shift.
// The scan ends when the remaining exponent is zero; the result is then held.
// One item at a time; in_stall is high from acceptance until result taken.
// Synchronous active-high reset returns to idle with no result pending.
`default_nettype none

module modular_exponentiation #(
  parameter int unsigned OPERAND_WIDTH = modexp_pkg::DefaultOperandWidth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] base_value,
  input  wire logic [31:0] exponent,
  input  wire logic [31:0] modulus,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      power_result
);
  import modexp_pkg::*;

  modexp_cmd_t  cmd;
  modexp_stat_t stat;

  modexp_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat
  );

  modexp_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk, .rst, .cmd, .stat, .base_value, .exponent, .modulus, .power_result
  );

endmodule

`default_nettype wire

@@ dv/modular_exponentiation_test.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_test: self-checking bench for modular_exponentiation
// Drives base/exponent/modulus items, predicts base^exp mod m with a local
// square-and-multiply, and checks every result in order under random idling.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_test;

  // Scoreboard: holds predicted powers in arrival order
  class power_scoreboard;
    logic [31:0] pending_powers[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Right-to-left square-and-multiply at 64-bit product width
    function logic [31:0] mod_power(logic [31:0] b, logic [31:0] e, logic [31:0] m);
      logic [63:0] acc;
      logic [63:0] sq;
      logic [31:0] rest;
      if (m == 0) return 32'd0;
      acc = 64'd1;
      sq = {32'd0, b} % {32'd0, m};
      rest = e;
      while (rest != 0) begin
        if (rest[0]) acc = (acc * sq) % {32'd0, m};
        rest = rest >> 1;
        sq = (sq * sq) % {32'd0, m};
      end
      return acc[31:0];
    endfunction

    function void note_item(logic [31:0] b, logic [31:0] e, logic [31:0] m);
      pending_powers.push_back(mod_power(b, e, m));
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending_powers.size() == 0) begin
        $display("%0t: unexpected result power_result=%h", $time, got);
        mismatches++;
        return;
      end
      want = pending_powers.pop_front();
      if (got !== want) begin
        $display("%0t: power_result expected %h actual %h", $time, want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] base_value;
  logic [31:0] exponent;
  logic [31:0] modulus;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] power_result;

  power_scoreboard powers;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;

  modular_exponentiation dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .base_value(base_value), .exponent(exponent), .modulus(modulus),
    .out_valid(out_valid), .out_stall(out_stall), .power_result(power_result)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: sample at rising edge, stall drives at falling edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) powers.check_result(power_result);
  end

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Present one item and hold it until accepted; returns at the next falling edge
  task automatic send_item(logic [31:0] b, logic [31:0] e, logic [31:0] m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    base_value <= b;
    exponent <= e;
    modulus <= m;
    do @(posedge clk); while (in_stall);
    powers.note_item(b, e, m);
    @(negedge clk);
  endtask

  // Random item: mostly short exponents, some full width
  task automatic send_random();
    logic [31:0] b;
    logic [31:0] e;
    logic [31:0] m;
    b = $urandom();
    case ($urandom_range(3))
      0: e = $urandom();
      1: e = $urandom_range(255);
      default: e = $urandom() >> $urandom_range(31);
    endcase
    case ($urandom_range(3))
      0: m = $urandom_range(1, 16);
      1: m = $urandom() >> $urandom_range(31);
      default: m = $urandom() | 32'h8000_0000;
    endcase
    if (m == 0) m = 1;
    send_item(b, e, m);
  endtask

  initial begin
    powers = new();
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    base_value = '0;
    exponent = '0;
    modulus = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: exponent zero, modulus one, extremes
    send_item(32'd5, 32'd0, 32'd1);
    send_item(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_item(32'd7, 32'd3, 32'd1);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    send_item(32'd0, 32'd5, 32'd13);
    send_item(32'd0, 32'd0, 32'd13);
    send_item(32'd2, 32'd10, 32'd1000);
    send_item(32'd3, 32'd200, 32'd1_000_000_007);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFB);
    send_item(32'h1234_5678, 32'h8000_0000, 32'h8000_0000);
    send_item(32'h8765_4321, 32'd1, 32'd2);
    send_item(32'd1, 32'hFFFF_FFFF, 32'd97);
    send_item(32'd12, 32'd1, 32'd5);
    send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFF1);

    // Random phases with varied idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin send_idle_pct = 52; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 52; end
        3: begin send_idle_pct = 11; recv_stall_pct = 11; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (51) send_random();
    end
    in_valid <= 1'b0;

    // Drain
    while (powers.pending_powers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (powers.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
design/modexp_pkg.sv
design/modexp_datapath.sv
design/modexp_ctrl.sv
design/modular_exponentiation.sv
dv/modular_exponentiation_test.sv
